// File: rtl/ohl_pkg.sv
// Shared types, constants and codes for the ordered handle list.
package ohl_pkg;

  localparam int unsigned Depth    = 16;
  localparam int unsigned HandleW  = 16;
  localparam int unsigned PosW     = 5;
  localparam int unsigned OpW      = 4;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned AddrW    = $clog2(Depth);
  localparam int unsigned CountW   = $clog2(Depth + 1);

  typedef logic [HandleW-1:0] handle_t;
  typedef logic [AddrW-1:0]   addr_t;
  typedef logic [CountW-1:0]  count_t;

  typedef enum logic [OpW-1:0] {
    OpReadAt     = 4'd0,
    OpInsertAt   = 4'd1,
    OpPushBack   = 4'd2,
    OpPushFront  = 4'd3,
    OpPushMiddle = 4'd4,
    OpRemove     = 4'd5,
    OpNext       = 4'd6,
    OpPrev       = 4'd7,
    OpExists     = 4'd8,
    OpClear      = 4'd9
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk         = 3'd0,
    StNotFound   = 3'd1,
    StNoNeighbor = 3'd2,
    StRange      = 3'd3,
    StFull       = 3'd4
  } status_e;

  typedef struct packed {
    logic    we;
    addr_t   waddr;
    handle_t wdata;
    logic    re;
    addr_t   raddr;
  } mem_req_t;

  typedef struct packed {
    logic    valid;
    status_e status;
    handle_t handle;
    logic    found;
    count_t  count;
  } res_t;

endpackage

// File: rtl/ohl_mem.sv
// Entry memory: one write port, one read port with registered read data.
module ohl_mem (
  input  logic              clk_i,
  input  ohl_pkg::mem_req_t req_i,
  output ohl_pkg::handle_t  rdata_o
);

  ohl_pkg::handle_t mem_q [ohl_pkg::Depth];
  ohl_pkg::handle_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ohl_seq.sv
// Sequencer: walks the entry memory to search, shift up for inserts and shift down for removes.
module ohl_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [3:0]        operation_i,
  input  ohl_pkg::handle_t  handle_i,
  input  logic [4:0]        position_i,
  output logic              busy,
  output ohl_pkg::mem_req_t mem_req_o,
  input  ohl_pkg::handle_t  mem_rdata_i,
  output ohl_pkg::res_t     res_o
);

  typedef enum logic [5:0] {
    SIdle  = 6'b000001,
    SRead  = 6'b000010,
    SScan  = 6'b000100,
    SShift = 6'b001000,
    SPut   = 6'b010000,
    SFin   = 6'b100000
  } state_e;

  localparam ohl_pkg::count_t CntOne  = ohl_pkg::CountW'(1);
  localparam ohl_pkg::count_t CntFull = ohl_pkg::CountW'(ohl_pkg::Depth);
  localparam ohl_pkg::addr_t  AddrOne = ohl_pkg::AddrW'(1);

  state_e            state_q, state_d;
  ohl_pkg::op_e      op_q, op_d;
  ohl_pkg::handle_t  h_q, h_d;
  ohl_pkg::addr_t    p_q, p_d;
  ohl_pkg::count_t   cnt_q, cnt_d;
  ohl_pkg::count_t   iss_q, iss_d;
  logic              iss_on_q, iss_on_d;
  logic              rd_vld_q, rd_vld_d;
  ohl_pkg::addr_t    rd_idx_q, rd_idx_d;
  logic              hit_q, hit_d;
  ohl_pkg::addr_t    hit_idx_q, hit_idx_d;
  ohl_pkg::handle_t  last_q, last_d;
  ohl_pkg::handle_t  pred_q, pred_d;
  logic              pred_ok_q, pred_ok_d;
  ohl_pkg::handle_t  succ_q, succ_d;
  logic              succ_ok_q, succ_ok_d;
  ohl_pkg::res_t     res_q, res_d;

  ohl_pkg::count_t   ins_pos;
  logic              do_ins;
  logic              match;
  logic              last_ret;
  ohl_pkg::count_t   pos_c;

  assign pos_c    = ohl_pkg::CountW'(position_i);
  assign match    = (mem_rdata_i == h_q);
  assign last_ret = (ohl_pkg::CountW'(rd_idx_q) == ohl_pkg::CountW'(cnt_q - CntOne));
  assign busy     = (state_q != SIdle);
  assign res_o    = res_q;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    h_d       = h_q;
    p_d       = p_q;
    cnt_d     = cnt_q;
    iss_d     = iss_q;
    iss_on_d  = iss_on_q;
    rd_vld_d  = 1'b0;
    rd_idx_d  = rd_idx_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    last_d    = last_q;
    pred_d    = pred_q;
    pred_ok_d = pred_ok_q;
    succ_d    = succ_q;
    succ_ok_d = succ_ok_q;
    res_d        = '0;
    res_d.status = ohl_pkg::StOk;
    res_d.count  = cnt_q;
    mem_req_o = '0;
    ins_pos   = '0;
    do_ins    = 1'b0;

    case (state_q)
      SIdle: begin
        if (start) begin
          op_d      = ohl_pkg::op_e'(operation_i);
          h_d       = handle_i;
          hit_d     = 1'b0;
          pred_ok_d = 1'b0;
          succ_ok_d = 1'b0;
          iss_d     = '0;
          case (ohl_pkg::op_e'(operation_i))
            ohl_pkg::OpReadAt: begin
              if (pos_c < cnt_q) begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = position_i[ohl_pkg::AddrW-1:0];
                state_d         = SRead;
              end else begin
                res_d.valid  = 1'b1;
                res_d.status = ohl_pkg::StRange;
              end
            end
            ohl_pkg::OpInsertAt: begin
              if (pos_c > cnt_q) begin
                res_d.valid  = 1'b1;
                res_d.status = ohl_pkg::StRange;
              end else if (cnt_q == CntFull) begin
                res_d.valid  = 1'b1;
                res_d.status = ohl_pkg::StFull;
              end else begin
                do_ins  = 1'b1;
                ins_pos = pos_c;
              end
            end
            ohl_pkg::OpPushBack, ohl_pkg::OpPushFront, ohl_pkg::OpPushMiddle: begin
              if (cnt_q == CntFull) begin
                res_d.valid  = 1'b1;
                res_d.status = ohl_pkg::StFull;
              end else begin
                do_ins = 1'b1;
                if (ohl_pkg::op_e'(operation_i) == ohl_pkg::OpPushBack) begin
                  ins_pos = cnt_q;
                end else if (ohl_pkg::op_e'(operation_i) == ohl_pkg::OpPushFront) begin
                  ins_pos = '0;
                end else begin
                  ins_pos = cnt_q >> 1;
                end
              end
            end
            ohl_pkg::OpRemove, ohl_pkg::OpNext, ohl_pkg::OpPrev, ohl_pkg::OpExists: begin
              if (cnt_q == '0) begin
                res_d.valid = 1'b1;
                if (ohl_pkg::op_e'(operation_i) != ohl_pkg::OpExists) begin
                  res_d.status = ohl_pkg::StNotFound;
                end
              end else begin
                state_d = SScan;
              end
            end
            ohl_pkg::OpClear: begin
              cnt_d       = '0;
              res_d.valid = 1'b1;
              res_d.count = '0;
            end
            default: begin
              res_d.valid = 1'b1;
            end
          endcase
          if (do_ins) begin
            p_d = ins_pos[ohl_pkg::AddrW-1:0];
            if (ins_pos == cnt_q) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = ins_pos[ohl_pkg::AddrW-1:0];
              mem_req_o.wdata = handle_i;
              cnt_d           = cnt_q + CntOne;
              res_d.valid     = 1'b1;
              res_d.count     = cnt_q + CntOne;
            end else begin
              iss_d    = cnt_q - CntOne;
              iss_on_d = 1'b1;
              state_d  = SShift;
            end
          end
        end
      end

      SRead: begin
        res_d.valid  = 1'b1;
        res_d.handle = mem_rdata_i;
        state_d      = SIdle;
      end

      SScan: begin
        if (iss_q < cnt_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = iss_q[ohl_pkg::AddrW-1:0];
          iss_d           = iss_q + CntOne;
          rd_vld_d        = 1'b1;
          rd_idx_d        = iss_q[ohl_pkg::AddrW-1:0];
        end
        if (rd_vld_q) begin
          last_d = mem_rdata_i;
          if (!hit_q && match) begin
            hit_d     = 1'b1;
            hit_idx_d = rd_idx_q;
            pred_d    = last_q;
            pred_ok_d = (rd_idx_q != '0);
          end else if (hit_q) begin
            if (rd_idx_q == hit_idx_q + AddrOne) begin
              succ_d    = mem_rdata_i;
              succ_ok_d = 1'b1;
            end
            if (op_q == ohl_pkg::OpRemove) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.waddr = rd_idx_q - AddrOne;
              mem_req_o.wdata = mem_rdata_i;
            end
          end
          if (last_ret) begin
            state_d = SFin;
          end
        end
      end

      SShift: begin
        if (iss_on_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = iss_q[ohl_pkg::AddrW-1:0];
          rd_vld_d        = 1'b1;
          rd_idx_d        = iss_q[ohl_pkg::AddrW-1:0];
          iss_d           = iss_q - CntOne;
          if (iss_q[ohl_pkg::AddrW-1:0] == p_q) begin
            iss_on_d = 1'b0;
          end
        end
        if (rd_vld_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = rd_idx_q + AddrOne;
          mem_req_o.wdata = mem_rdata_i;
          if (rd_idx_q == p_q) begin
            state_d = SPut;
          end
        end
      end

      SPut: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = p_q;
        mem_req_o.wdata = h_q;
        cnt_d           = cnt_q + CntOne;
        res_d.valid     = 1'b1;
        res_d.count     = cnt_q + CntOne;
        state_d         = SIdle;
      end

      SFin: begin
        res_d.valid = 1'b1;
        res_d.found = hit_q;
        state_d     = SIdle;
        case (op_q)
          ohl_pkg::OpRemove: begin
            if (hit_q) begin
              cnt_d       = cnt_q - CntOne;
              res_d.count = cnt_q - CntOne;
            end else begin
              res_d.status = ohl_pkg::StNotFound;
            end
          end
          ohl_pkg::OpNext: begin
            if (!hit_q) begin
              res_d.status = ohl_pkg::StNotFound;
            end else if (succ_ok_q) begin
              res_d.handle = succ_q;
            end else begin
              res_d.status = ohl_pkg::StNoNeighbor;
            end
          end
          ohl_pkg::OpPrev: begin
            if (!hit_q) begin
              res_d.status = ohl_pkg::StNotFound;
            end else if (pred_ok_q) begin
              res_d.handle = pred_q;
            end else begin
              res_d.status = ohl_pkg::StNoNeighbor;
            end
          end
          default: begin
          end
        endcase
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      cnt_q     <= '0;
      iss_on_q  <= 1'b0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      pred_ok_q <= 1'b0;
      succ_ok_q <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      iss_on_q  <= iss_on_d;
      rd_vld_q  <= rd_vld_d;
      hit_q     <= hit_d;
      pred_ok_q <= pred_ok_d;
      succ_ok_q <= succ_ok_d;
      res_q     <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    h_q       <= h_d;
    p_q       <= p_d;
    iss_q     <= iss_d;
    rd_idx_q  <= rd_idx_d;
    hit_idx_q <= hit_idx_d;
    last_q    <= last_d;
    pred_q    <= pred_d;
    succ_q    <= succ_d;
  end

endmodule

// File: rtl/ordered_handle_list.sv
// Ordered handle list: sequencer and entry memory.
// read_at via SRead; append and failed checks answer from idle; insert with shift
// moves entries up, then SPut; remove/next/prev/exists scan, then SFin (one read port).
// One transaction at a time: busy drops as done_o rises; start is taken only while idle.
// The result shows on the outputs for one cycle with done_o; the receiver cannot stall.
// Reset clears the count and control state; the entry memory is not cleared.
module ordered_handle_list (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  operation_i,
  input  logic [15:0] handle_i,
  input  logic [4:0]  position_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [15:0] handle_out_o,
  output logic        found_o,
  output logic [4:0]  count_o
);

  ohl_pkg::mem_req_t mem_req;
  ohl_pkg::handle_t  mem_rdata;
  ohl_pkg::res_t     res;

  ohl_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .handle_i    (handle_i),
    .position_i  (position_i),
    .busy        (busy),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_o       (res)
  );

  ohl_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign done_o       = res.valid;
  assign status_o     = res.status;
  assign handle_out_o = res.handle;
  assign found_o      = res.found;
  assign count_o      = res.count;

endmodule

// File: bench/tb_ordered_handle_list.sv
// Self-checking testbench for the ordered handle list: mirrored list, scoreboard, stimulus.
`timescale 1ns / 1ps

module tb_ordered_handle_list;

  localparam logic [3:0]  OpSpareLo  = 4'd10;
  localparam logic [3:0]  OpSpareHi  = 4'd15;
  localparam int unsigned MaxGap     = 19;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned ShownLimit = 10;

  typedef struct packed {
    ohl_pkg::status_e status;
    ohl_pkg::handle_t handle;
    logic             found;
    ohl_pkg::count_t  count;
  } outcome_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [3:0]  operation_i;
  logic [15:0] handle_i;
  logic [4:0]  position_i;
  logic        done_o;
  logic [2:0]  status_o;
  logic [15:0] handle_out_o;
  logic        found_o;
  logic [4:0]  count_o;

  ohl_pkg::handle_t mirror [ohl_pkg::Depth];
  int unsigned mirror_len;
  outcome_t    pending_outcomes [$];
  outcome_t    oldest;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned status_tally [5];
  bit          sender_burst;

  ordered_handle_list dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operation_i (operation_i),
    .handle_i    (handle_i),
    .position_i  (position_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .handle_out_o(handle_out_o),
    .found_o     (found_o),
    .count_o     (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int find_in_mirror(ohl_pkg::handle_t h);
    int unsigned i;
    for (i = 0; i < mirror_len; i++) begin
      if (mirror[i] == h) return int'(i);
    end
    return -1;
  endfunction

  function automatic void mirror_insert(int unsigned at, ohl_pkg::handle_t h);
    int unsigned i;
    for (i = mirror_len; i > at; i--) mirror[i] = mirror[i-1];
    mirror[at] = h;
    mirror_len++;
  endfunction

  // Apply one operation to the mirrored list and return the outcome it must produce.
  function automatic outcome_t apply_to_mirror(logic [3:0] op, ohl_pkg::handle_t h,
                                               logic [4:0] pos);
    outcome_t    r;
    int          idx;
    int unsigned p;
    int unsigned i;
    r.status = ohl_pkg::StOk;
    r.handle = '0;
    r.found  = 1'b0;
    p        = pos;
    idx      = find_in_mirror(h);
    case (op)
      ohl_pkg::OpReadAt: begin
        if (p < mirror_len) r.handle = mirror[p];
        else r.status = ohl_pkg::StRange;
      end
      ohl_pkg::OpInsertAt: begin
        if (p > mirror_len) r.status = ohl_pkg::StRange;
        else if (mirror_len >= ohl_pkg::Depth) r.status = ohl_pkg::StFull;
        else mirror_insert(p, h);
      end
      ohl_pkg::OpPushBack, ohl_pkg::OpPushFront, ohl_pkg::OpPushMiddle: begin
        if (mirror_len >= ohl_pkg::Depth) r.status = ohl_pkg::StFull;
        else if (op == ohl_pkg::OpPushBack) mirror_insert(mirror_len, h);
        else if (op == ohl_pkg::OpPushFront) mirror_insert(0, h);
        else mirror_insert(mirror_len / 2, h);
      end
      ohl_pkg::OpRemove: begin
        if (idx < 0) begin
          r.status = ohl_pkg::StNotFound;
        end else begin
          r.found = 1'b1;
          for (i = idx; i + 1 < mirror_len; i++) mirror[i] = mirror[i+1];
          mirror_len--;
        end
      end
      ohl_pkg::OpNext, ohl_pkg::OpPrev: begin
        if (idx < 0) begin
          r.status = ohl_pkg::StNotFound;
        end else begin
          r.found = 1'b1;
          if (op == ohl_pkg::OpNext) begin
            if (idx + 1 >= mirror_len) r.status = ohl_pkg::StNoNeighbor;
            else r.handle = mirror[idx+1];
          end else begin
            if (idx == 0) r.status = ohl_pkg::StNoNeighbor;
            else r.handle = mirror[idx-1];
          end
        end
      end
      ohl_pkg::OpExists: begin
        r.found = (idx >= 0);
      end
      ohl_pkg::OpClear: begin
        mirror_len = 0;
      end
      default: begin
      end
    endcase
    r.count = ohl_pkg::count_t'(mirror_len);
    return r;
  endfunction

  task automatic send_op(logic [3:0] op, ohl_pkg::handle_t h, logic [4:0] pos);
    int unsigned gap;
    outcome_t    expected;
    gap = sender_burst ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i = op;
    handle_i    = h;
    position_i  = pos;
    start       = 1'b1;
    do @(posedge clk_i); while (busy);
    expected = apply_to_mirror(op, h, pos);
    pending_outcomes.insert(pending_outcomes.size(), expected);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Hold the sender until every outstanding result has been checked.
  task automatic drain_results();
    start = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk_i);
  endtask

  function automatic ohl_pkg::handle_t any_handle();
    return ohl_pkg::handle_t'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic test_directed_cases();
    send_op(ohl_pkg::OpClear, 16'h0000, 5'd0);
    send_op(ohl_pkg::OpReadAt, 16'h0000, 5'd0);
    send_op(ohl_pkg::OpRemove, 16'h1234, 5'd0);
    send_op(ohl_pkg::OpNext, 16'h1234, 5'd0);
    send_op(ohl_pkg::OpPushBack, 16'hFFFF, 5'd0);
    send_op(ohl_pkg::OpPushFront, 16'h0000, 5'd16);
    send_op(ohl_pkg::OpPushMiddle, 16'h00AA, 5'd0);
    send_op(ohl_pkg::OpInsertAt, 16'h5555, 5'd3);
    send_op(ohl_pkg::OpInsertAt, 16'hAAAA, 5'd16);
    send_op(ohl_pkg::OpPushBack, 16'h00AA, 5'd0);
    send_op(ohl_pkg::OpNext, 16'h00AA, 5'd0);
    send_op(ohl_pkg::OpPrev, 16'h0000, 5'd0);
    send_op(ohl_pkg::OpPrev, 16'h00AA, 5'd0);
    send_op(ohl_pkg::OpRemove, 16'h00AA, 5'd0);
    send_op(ohl_pkg::OpNext, 16'h00AA, 5'd0);
    send_op(ohl_pkg::OpRemove, 16'h1234, 5'd0);
    send_op(ohl_pkg::OpExists, 16'hFFFF, 5'd0);
    send_op(ohl_pkg::OpExists, 16'h1234, 5'd0);
    send_op(ohl_pkg::OpReadAt, 16'h0000, 5'd3);
    send_op(ohl_pkg::OpReadAt, 16'h0000, 5'd4);
    send_op(OpSpareLo, 16'hFFFF, 5'd31);
    send_op(OpSpareHi, 16'h0000, 5'd0);
    send_op(ohl_pkg::OpClear, 16'h0000, 5'd0);
    send_op(ohl_pkg::OpReadAt, 16'h0000, 5'd0);
    send_op(ohl_pkg::OpExists, 16'h0000, 5'd0);
    drain_results();
  endtask

  task automatic test_full_list();
    logic [3:0] op;
    while (mirror_len < ohl_pkg::Depth) begin
      case ($urandom_range(0, 3))
        0: op = ohl_pkg::OpInsertAt;
        1: op = ohl_pkg::OpPushBack;
        2: op = ohl_pkg::OpPushFront;
        default: op = ohl_pkg::OpPushMiddle;
      endcase
      send_op(op, any_handle(), 5'($urandom_range(0, mirror_len)));
    end
    send_op(ohl_pkg::OpPushBack, 16'hFFFF, 5'd0);
    send_op(ohl_pkg::OpPushFront, 16'h0000, 5'd0);
    send_op(ohl_pkg::OpPushMiddle, 16'h1111, 5'd0);
    send_op(ohl_pkg::OpInsertAt, 16'h2222, 5'd16);
    send_op(ohl_pkg::OpInsertAt, 16'h3333, 5'd0);
    send_op(ohl_pkg::OpReadAt, 16'h0000, 5'd15);
    send_op(ohl_pkg::OpReadAt, 16'h0000, 5'd16);
    send_op(ohl_pkg::OpNext, mirror[ohl_pkg::Depth-1], 5'd0);
    send_op(ohl_pkg::OpPrev, mirror[0], 5'd0);
    drain_results();
    send_op(ohl_pkg::OpClear, any_handle(), 5'd0);
    drain_results();
  endtask

  task automatic run_random_ops(int unsigned n, int unsigned insert_pct, int unsigned remove_pct);
    logic [3:0]       op;
    ohl_pkg::handle_t h;
    logic [4:0]       pos;
    int unsigned      roll;
    int unsigned      k;
    for (k = 0; k < n; k++) begin
      if (k % 40 == 0) sender_burst = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      h    = any_handle();
      pos  = 5'($urandom_range(0, ohl_pkg::Depth));
      if (roll < insert_pct) begin
        case ($urandom_range(0, 3))
          0: op = ohl_pkg::OpInsertAt;
          1: op = ohl_pkg::OpPushBack;
          2: op = ohl_pkg::OpPushFront;
          default: op = ohl_pkg::OpPushMiddle;
        endcase
        if ($urandom_range(0, 2) == 0) h = ohl_pkg::handle_t'($urandom_range(0, 7)) << 13;
        if ($urandom_range(0, 9) != 0) pos = 5'($urandom_range(0, mirror_len));
      end else if (roll < 98) begin
        if (roll < insert_pct + remove_pct) begin
          op = ohl_pkg::OpRemove;
        end else begin
          case ($urandom_range(0, 3))
            0: op = ohl_pkg::OpReadAt;
            1: op = ohl_pkg::OpNext;
            2: op = ohl_pkg::OpPrev;
            default: op = ohl_pkg::OpExists;
          endcase
        end
        if (mirror_len > 0 && $urandom_range(0, 4) != 0) begin
          h = mirror[$urandom_range(0, mirror_len - 1)];
        end
        if (mirror_len > 0 && $urandom_range(0, 9) != 0) begin
          pos = 5'($urandom_range(0, mirror_len - 1));
        end
      end else if (roll == 98) begin
        op = ohl_pkg::OpClear;
      end else begin
        op = 4'($urandom_range(OpSpareLo, OpSpareHi));
      end
      send_op(op, h, pos);
    end
    sender_burst = 1'b0;
    drain_results();
  endtask

  task automatic test_random_traffic();
    run_random_ops(350, 55, 15);
    run_random_ops(350, 20, 45);
    run_random_ops(700, 35, 30);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (status_o < 5) status_tally[status_o]++;
      if (pending_outcomes.size() == 0) begin
        if (mismatch_count < ShownLimit) begin
          $display("unexpected result: status %0d handle %h found %0d count %0d",
                   status_o, handle_out_o, found_o, count_o);
        end
        mismatch_count++;
      end else begin
        oldest = pending_outcomes.pop_front();
        results_checked++;
        if (status_o !== oldest.status || handle_out_o !== oldest.handle ||
            found_o !== oldest.found || count_o !== oldest.count) begin
          if (mismatch_count < ShownLimit) begin
            $display("result %0d: expected %0d/%h/%0d/%0d, got %0d/%h/%0d/%0d",
                     results_checked, oldest.status, oldest.handle, oldest.found,
                     oldest.count, status_o, handle_out_o, found_o, count_o);
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("timeout: no transaction for %0d cycles", StallLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    operation_i  = '0;
    handle_i     = '0;
    position_i   = '0;
    mirror_len   = 0;
    sender_burst = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_full_list();
    test_random_traffic();

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    $display("%0d transactions sent, %0d results checked, %0d mismatches",
             items_sent, results_checked, mismatch_count);
    $display("statuses seen: ok %0d, not found %0d, no neighbor %0d, range %0d, full %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ohl_pkg.sv
rtl/ohl_mem.sv
rtl/ohl_seq.sv
rtl/ordered_handle_list.sv
bench/tb_ordered_handle_list.sv
